@@ src/mbe_pkg.sv @@
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, constants and saturating helpers for the escape-time pixel
// engine.
// ----------------------------------------------------------------------------
package mbe_pkg;

  // channel widths (payload packed from bit 0, padded to whole bytes)
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 64;

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_RE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_IM = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP_RE   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP_IM   = 2'd3;

  // reset values, Q7.56
  localparam logic signed [63:0] ORIGIN_RE_RST = -64'sd180143985094819840;
  localparam logic signed [63:0] ORIGIN_IM_RST = -64'sd72057594037927936;
  localparam logic signed [63:0] STEP_RE_RST   = 64'sd184763061635712;
  localparam logic signed [63:0] STEP_IM_RST   = 64'sd187894638951572;

  localparam logic signed [63:0] FX_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] FX_MIN = {1'b1, {63{1'b0}}};

  // palette segments
  localparam logic [1:0] SEG_RG = 2'd0;  // red to green
  localparam logic [1:0] SEG_GB = 2'd1;  // green to blue
  localparam logic [1:0] SEG_BF = 2'd2;  // blue fading out

  // request to the shared multiplier
  typedef struct packed {
    logic start;
    logic fx_mode;  // 1: fixed-point product, 0: integer product (coordinate map)
    logic neg;      // sign of the product
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_rsp_t;

  function automatic logic signed [63:0] sat65(input logic [64:0] v);
    if (v[64] != v[63]) begin
      return v[64] ? FX_MIN : FX_MAX;
    end
    return v[63:0];
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    return sat65({a[63], a} + {b[63], b});
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    return sat65({a[63], a} - {b[63], b});
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

@@ src/mbe_mul.sv @@
// ----------------------------------------------------------------------------
// mbe_mul
// Shared 64x64 sign-magnitude multiplier built from one 32x32 multiplier,
// four partial products per request, with floor rounding and saturation.
// ----------------------------------------------------------------------------
module mbe_mul import mbe_pkg::*; #(
  parameter int FRAC_BITS = 56
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mul_req_t            req,
  input  logic [63:0]         a_mag,
  input  logic [63:0]         b_mag,
  output mul_rsp_t            rsp,
  output logic signed [63:0]  res
);

  logic        busy_r, busy_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [63:0] a_r, b_r;
  logic        fx_r, neg_r;
  logic [63:0] p_r;
  logic [1:0]  sh_r;
  logic [127:0] acc_r;
  logic signed [63:0] res_r;

  logic [31:0]  a_h, b_h;
  logic [63:0]  prod;
  logic [1:0]   sh;
  logic [127:0] pp;
  logic         ovf, rnd;
  logic [63:0]  q;
  logic signed [63:0] fin;

  // cnt 0..3: a0*b0, a0*b1, a1*b0, a1*b1
  assign a_h  = cnt_r[1] ? a_r[63:32] : a_r[31:0];
  assign b_h  = cnt_r[0] ? b_r[63:32] : b_r[31:0];
  assign prod = a_h * b_h;
  assign sh   = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
  assign pp   = {64'd0, p_r} << {sh_r, 5'd0};

  always_comb begin
    ovf = fx_r ? (|acc_r[127:64+FRAC_BITS]) : (|acc_r[127:64]);
    q   = fx_r ? acc_r[FRAC_BITS+63:FRAC_BITS] : acc_r[63:0];
    rnd = fx_r && neg_r && (|acc_r[FRAC_BITS-1:0]);
    if (ovf) begin
      fin = neg_r ? FX_MIN : FX_MAX;
    end else if (neg_r) begin
      // -(q + 1) is ~q
      if (rnd ? (q >= 64'h7FFF_FFFF_FFFF_FFFF) : (q >= 64'h8000_0000_0000_0000)) begin
        fin = FX_MIN;
      end else begin
        fin = rnd ? ~q : (64'd0 - q);
      end
    end else begin
      fin = q[63] ? FX_MAX : q;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd5) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 3'd0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      a_r   <= a_mag;
      b_r   <= b_mag;
      fx_r  <= req.fx_mode;
      neg_r <= req.neg;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r <= 3'd3) begin
        p_r  <= prod;
        sh_r <= sh;
      end
      if (cnt_r >= 3'd1 && cnt_r <= 3'd4) begin
        acc_r <= acc_r + pp;
      end
      if (cnt_r == 3'd5) begin
        res_r <= fin;
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign res      = res_r;

endmodule

@@ src/mbe_pal.sv @@
// ----------------------------------------------------------------------------
// mbe_pal
// Three-segment palette: picks the segment from the iteration count and
// finds the ramp value by reciprocal multiplication with the segment length.
// ----------------------------------------------------------------------------
module mbe_pal import mbe_pkg::*; #(
  parameter int MAX_ITER = 256,
  parameter int CNT_W    = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] n,
  input  logic             esc,
  output logic             done,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue
);

  localparam int SEG = MAX_ITER / 3;
  localparam int DW  = CNT_W + 8;
  // floor(x / SEG) is (x * RECIP) >> QK for every x below 2**DW
  localparam int QK  = DW + $clog2(SEG);
  localparam int MW  = DW + 2;
  localparam int QW  = DW + MW - QK;
  localparam logic [MW-1:0] RECIP =
    MW'(((longint'(1) << QK) + longint'(SEG) - 1) / longint'(SEG));

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_DIV  = 2'd1;
  localparam logic [1:0] P_FIN  = 2'd2;

  logic [1:0]     state_r, state_nxt;
  logic           done_r, done_nxt;
  logic           esc_r;
  logic [1:0]     seg_r;
  logic [DW-1:0]  num_r;
  logic [QW-1:0]  quo_r;
  logic [7:0]     red_r, green_r, blue_r;

  logic [1:0]       seg_sel;
  logic [CNT_W-1:0] t;
  logic [DW-1:0]    num0;
  logic [DW+MW-1:0] prod;
  logic [7:0]       v;

  always_comb begin
    if (n < CNT_W'(SEG)) begin
      seg_sel = SEG_RG;
      t       = n;
    end else if (n < CNT_W'(2 * SEG)) begin
      seg_sel = SEG_GB;
      t       = n - CNT_W'(SEG);
    end else begin
      seg_sel = SEG_BF;
      t       = n - CNT_W'(2 * SEG);
    end
    // t * 255
    num0 = {t, 8'd0} - {8'd0, t};
  end

  assign prod = num_r * RECIP;
  assign v    = (|quo_r[QW-1:8]) ? 8'hFF : quo_r[7:0];

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    case (state_r)
      P_IDLE: begin
        if (start) begin
          state_nxt = esc ? P_DIV : P_FIN;
        end
      end
      P_DIV: begin
        state_nxt = P_FIN;
      end
      P_FIN: begin
        done_nxt  = 1'b1;
        state_nxt = P_IDLE;
      end
      default: state_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == P_IDLE && start) begin
      esc_r <= esc;
      seg_r <= seg_sel;
      num_r <= num0;
    end
    if (state_r == P_DIV) begin
      quo_r <= prod[DW+MW-1:QK];
    end
    if (state_r == P_FIN) begin
      red_r   <= 8'd0;
      green_r <= 8'd0;
      blue_r  <= 8'd0;
      if (esc_r) begin
        case (seg_r)
          SEG_RG: begin
            red_r   <= 8'hFF - v;
            green_r <= v;
          end
          SEG_GB: begin
            green_r <= 8'hFF - v;
            blue_r  <= v;
          end
          default: blue_r <= 8'hFF - v;
        endcase
      end
    end
  end

  assign done  = done_r;
  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == P_IDLE))
    else $error("palette request while busy");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && !esc_r) |-> (red_r == 8'd0 && green_r == 8'd0 && blue_r == 8'd0))
    else $error("point that stayed bounded is not black");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("palette done held for more than one cycle");
`endif

endmodule

@@ src/mandelbrot_escape_time_pixel.sv @@
// One pixel request (pixel_x, pixel_y) is mapped to c = origin + step * coordinate and
// z = z*z + c is iterated in Q(63-FRAC_BITS).FRAC_BITS fixed point until |z|^2 reaches
// four or MAX_ITER iterations are done; one result (count, escape flag, RGB) follows.
// All products go through a single shared 32x32 multiplier, four partial products per
// 64-bit product. The escaping iteration skips the cross product and the z update, and
// the palette skips its division step for a point that stays bounded. The block takes
// one request at a time; a finished result waits in the output register while the next
// request is accepted.
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time pixel engine: coordinate map, iteration sequencer, palette.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel import mbe_pkg::*; #(
  parameter int MAX_ITER  = 256,
  parameter int FRAC_BITS = 56
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // pixel_x[10:0], pixel_y[20:11], pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // iter_count[8:0], escaped[9], red[17:10],
                                             // green[25:18], blue[33:26], pad
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_ITER + 1);
  localparam logic signed [63:0] FOUR_FX = 64'sd4 << FRAC_BITS;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MAP_RE = 4'd1;
  localparam logic [3:0] S_MAP_IM = 4'd2;
  localparam logic [3:0] S_SQ_RE  = 4'd3;
  localparam logic [3:0] S_SQ_IM  = 4'd4;
  localparam logic [3:0] S_CHECK  = 4'd5;
  localparam logic [3:0] S_CROSS  = 4'd6;
  localparam logic [3:0] S_UPD_A  = 4'd7;
  localparam logic [3:0] S_UPD_B  = 4'd8;
  localparam logic [3:0] S_PAL    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       issued_r, issued_nxt;
  logic       esc_r, esc_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic signed [63:0] origin_re_r, origin_im_r, step_re_r, step_im_r;
  logic [10:0] px_r;
  logic [9:0]  py_r;
  logic signed [63:0] cr_r, ci_r, zr_r, zi_r, sr_r, si_r, cross_r;
  logic signed [63:0] cr_nxt, ci_nxt, zr_nxt, zi_nxt, sr_nxt, si_nxt, cross_nxt;
  logic [8:0] out_iter_r;
  logic       out_esc_r;
  logic [7:0] out_red_r, out_green_r, out_blue_r;

  mul_req_t    mul_req;
  mul_rsp_t    mul_rsp;
  logic [63:0] mul_a, mul_b;
  logic signed [63:0] mul_res;
  logic        pal_start, pal_done;
  logic [7:0]  pal_red, pal_green, pal_blue;
  logic signed [63:0] d;
  logic        accept, out_load;

  mbe_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .a_mag (mul_a),
    .b_mag (mul_b),
    .rsp   (mul_rsp),
    .res   (mul_res)
  );

  mbe_pal #(.MAX_ITER(MAX_ITER), .CNT_W(CNT_W)) u_pal (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pal_start),
    .n     (n_r),
    .esc   (esc_r),
    .done  (pal_done),
    .red   (pal_red),
    .green (pal_green),
    .blue  (pal_blue)
  );

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign d         = sat_add(sr_r, si_r);
  assign pal_start = (state_r == S_PAL) && !issued_r;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // multiplier operand select
  always_comb begin
    mul_req.start   = 1'b0;
    mul_req.fx_mode = 1'b1;
    mul_req.neg     = 1'b0;
    mul_a           = mag64(zr_r);
    mul_b           = mag64(zr_r);
    case (state_r)
      S_MAP_RE: begin
        mul_req.fx_mode = 1'b0;
        mul_req.neg     = step_re_r[63];
        mul_a           = mag64(step_re_r);
        mul_b           = {53'd0, px_r};
      end
      S_MAP_IM: begin
        mul_req.fx_mode = 1'b0;
        mul_req.neg     = step_im_r[63];
        mul_a           = mag64(step_im_r);
        mul_b           = {54'd0, py_r};
      end
      S_SQ_IM: begin
        mul_a = mag64(zi_r);
        mul_b = mag64(zi_r);
      end
      S_CROSS: begin
        mul_req.neg = zr_r[63] ^ zi_r[63];
        mul_b       = mag64(zi_r);
      end
      default: ;
    endcase
    if (state_r == S_MAP_RE || state_r == S_MAP_IM || state_r == S_SQ_RE ||
        state_r == S_SQ_IM || state_r == S_CROSS) begin
      mul_req.start = !issued_r;
    end
  end

  // iteration sequencer
  always_comb begin
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    esc_nxt       = esc_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    sr_nxt        = sr_r;
    si_nxt        = si_r;
    cross_nxt     = cross_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (mul_req.start || pal_start) begin
      issued_nxt = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_MAP_RE;
        end
      end
      S_MAP_RE: begin
        if (mul_rsp.done) begin
          issued_nxt = 1'b0;
          cr_nxt     = sat_add(origin_re_r, mul_res);
          state_nxt  = S_MAP_IM;
        end
      end
      S_MAP_IM: begin
        if (mul_rsp.done) begin
          issued_nxt = 1'b0;
          ci_nxt     = sat_add(origin_im_r, mul_res);
          zr_nxt     = '0;
          zi_nxt     = '0;
          n_nxt      = '0;
          esc_nxt    = 1'b0;
          state_nxt  = S_SQ_RE;
        end
      end
      S_SQ_RE: begin
        if (mul_rsp.done) begin
          issued_nxt = 1'b0;
          sr_nxt     = mul_res;
          state_nxt  = S_SQ_IM;
        end
      end
      S_SQ_IM: begin
        if (mul_rsp.done) begin
          issued_nxt = 1'b0;
          si_nxt     = mul_res;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (d >= FOUR_FX) begin
          esc_nxt   = 1'b1;
          state_nxt = S_PAL;
        end else begin
          state_nxt = S_CROSS;
        end
      end
      S_CROSS: begin
        if (mul_rsp.done) begin
          issued_nxt = 1'b0;
          cross_nxt  = mul_res;
          state_nxt  = S_UPD_A;
        end
      end
      S_UPD_A: begin
        // sr holds sr - si, cross holds 2 * cross from here on
        sr_nxt    = sat_sub(sr_r, si_r);
        cross_nxt = sat_add(cross_r, cross_r);
        state_nxt = S_UPD_B;
      end
      S_UPD_B: begin
        zr_nxt = sat_add(sr_r, cr_r);
        zi_nxt = sat_add(cross_r, ci_r);
        n_nxt  = n_r + 1'b1;
        state_nxt = (n_r == CNT_W'(MAX_ITER - 1)) ? S_PAL : S_SQ_RE;
      end
      S_PAL: begin
        if (pal_done) begin
          issued_nxt = 1'b0;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      origin_re_r <= ORIGIN_RE_RST;
      origin_im_r <= ORIGIN_IM_RST;
      step_re_r   <= STEP_RE_RST;
      step_im_r   <= STEP_IM_RST;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ORIGIN_RE: origin_re_r <= cfg_wdata;
          CFG_ORIGIN_IM: origin_im_r <= cfg_wdata;
          CFG_STEP_RE:   step_re_r   <= cfg_wdata;
          CFG_STEP_IM:   step_im_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_tdata[10:0];
      py_r <= in_tdata[20:11];
    end
    esc_r   <= esc_nxt;
    n_r     <= n_nxt;
    cr_r    <= cr_nxt;
    ci_r    <= ci_nxt;
    zr_r    <= zr_nxt;
    zi_r    <= zi_nxt;
    sr_r    <= sr_nxt;
    si_r    <= si_nxt;
    cross_r <= cross_nxt;
    if (out_load) begin
      out_iter_r  <= 9'(n_r);
      out_esc_r   <= esc_r;
      out_red_r   <= pal_red;
      out_green_r <= pal_green;
      out_blue_r  <= pal_blue;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_blue_r, out_green_r, out_red_r, out_esc_r, out_iter_r};

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("request accepted while the previous one is in flight");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (n_r < CNT_W'(MAX_ITER)))
    else $error("escape test beyond the iteration limit");

  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");
`endif

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the escape-time pixel engine. Pixel requests go in
// over the input stream, an in-bench fixed-point model predicts count, escape
// flag and palette colour, and every result is compared with the oldest
// prediction. Views are changed through the register port between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import mbe_pkg::*;;

  localparam int MAX_ITER    = 256;
  localparam int FRAC_BITS   = 56;
  localparam int SEG         = MAX_ITER / 3;
  localparam int HOLD_CYCLES = 600;
  // worst case: every pixel stays bounded, plus stalls, taken four times over
  localparam longint LIMIT_CYCLES = 64'd1200 * 7200 * 4;

  localparam logic signed [63:0] FOUR = 64'sd4 <<< FRAC_BITS;

  typedef struct packed {
    logic [8:0] iter_count;
    logic       escaped;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // pixel_x[10:0], pixel_y[20:11], pad
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // iter_count[8:0], escaped[9], red[17:10],
                                            // green[25:18], blue[33:26], pad
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  // view registers as the block should hold them
  logic signed [63:0] view_ore = ORIGIN_RE_RST;
  logic signed [63:0] view_oim = ORIGIN_IM_RST;
  logic signed [63:0] view_sre = STEP_RE_RST;
  logic signed [63:0] view_sim = STEP_IM_RST;

  pixel_result_t pending[$];
  int            mismatches = 0;
  bit            steady     = 1'b0;
  int            hold_req   = 0;
  int            hold_seen  = 0;
  int            hold_left  = 0;

  mandelbrot_escape_time_pixel #(
    .MAX_ITER (MAX_ITER),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic logic signed [63:0] clamp_sum(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      return a[63] ? FX_MIN : FX_MAX;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] clamp_diff(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
    logic signed [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) begin
      return a[63] ? FX_MIN : FX_MAX;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] m);
    if (neg) begin
      if (m[63]) begin
        return FX_MIN;
      end
      return 64'd0 - m;
    end
    if (m[63]) begin
      return FX_MAX;
    end
    return m;
  endfunction

  // fixed-point product, floor rounding, saturated
  function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic         neg;
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [63:0]  q;
    logic [127:0] p;
    neg = a[63] ^ b[63];
    ma  = a[63] ? (~a + 64'd1) : a;
    mb  = b[63] ? (~b + 64'd1) : b;
    p   = {64'd0, ma} * {64'd0, mb};
    if (p[127:64+FRAC_BITS] != '0) begin
      return neg ? FX_MIN : FX_MAX;
    end
    q = p[FRAC_BITS +: 64];
    if (neg && p[FRAC_BITS-1:0] != '0) begin
      q = q + 64'd1;
      if (q == '0) begin
        return FX_MIN;
      end
    end
    return from_mag(neg, q);
  endfunction

  function automatic logic signed [63:0] to_point(input logic signed [63:0] origin,
                                                  input logic signed [63:0] step,
                                                  input logic [10:0] coord);
    logic [63:0]        ms;
    logic [127:0]       p;
    logic signed [63:0] prod;
    ms = step[63] ? (~step + 64'd1) : step;
    p  = {64'd0, ms} * {117'd0, coord};
    if (p[127:64] != '0) begin
      prod = step[63] ? FX_MIN : FX_MAX;
    end else begin
      prod = from_mag(step[63], p[63:0]);
    end
    return clamp_sum(origin, prod);
  endfunction

  function automatic int ramp255(input int t);
    int v;
    v = t * 255 / SEG;
    return (v > 255) ? 255 : v;
  endfunction

  function automatic pixel_result_t escape_pixel(input logic [10:0] px, input logic [9:0] py);
    pixel_result_t      res;
    logic signed [63:0] cr;
    logic signed [63:0] ci;
    logic signed [63:0] zr;
    logic signed [63:0] zi;
    logic signed [63:0] sr;
    logic signed [63:0] si;
    logic signed [63:0] xprod;
    int                 n;
    logic               esc;
    cr  = to_point(view_ore, view_sre, px);
    ci  = to_point(view_oim, view_sim, {1'b0, py});
    zr  = '0;
    zi  = '0;
    n   = 0;
    esc = 1'b0;
    while (n < MAX_ITER && !esc) begin
      sr = q_mul(zr, zr);
      si = q_mul(zi, zi);
      if (clamp_sum(sr, si) >= FOUR) begin
        esc = 1'b1;
      end else begin
        xprod = q_mul(zr, zi);
        zi    = clamp_sum(clamp_sum(xprod, xprod), ci);
        zr    = clamp_sum(clamp_diff(sr, si), cr);
        n++;
      end
    end
    res            = '0;
    res.iter_count = n[8:0];
    res.escaped    = esc;
    if (esc) begin
      if (n < SEG) begin
        res.red   = 8'(255 - ramp255(n));
        res.green = 8'(ramp255(n));
      end else if (n < 2 * SEG) begin
        res.green = 8'(255 - ramp255(n - SEG));
        res.blue  = 8'(ramp255(n - SEG));
      end else begin
        res.blue  = 8'(255 - ramp255(n - 2 * SEG));
      end
    end
    return res;
  endfunction

  // thousandths to Q7.56
  function automatic logic signed [63:0] milli(input int k);
    return longint'(k) * 64'sd72057594037927;
  endfunction

  function automatic logic signed [63:0] rand_step(input int shift);
    logic [63:0] r;
    r = {$urandom, $urandom} >> shift;
    return ($urandom_range(0, 1) == 1) ? (64'd0 - r) : r;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_pixel(input logic [10:0] px, input logic [9:0] py);
    if (!steady) begin
      while ($urandom_range(0, 99) < 34) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'd0, py, px};
    do @(posedge clk); while (!in_tready);
    pending.push_back(escape_pixel(px, py));
  endtask

  task automatic send_random_pixel();
    send_pixel(11'($urandom_range(0, 2047)), 10'($urandom_range(0, 1023)));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  // only called with nothing in flight
  task automatic set_view(input logic signed [63:0] ore, input logic signed [63:0] oim,
                          input logic signed [63:0] sre, input logic signed [63:0] sim);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_ORIGIN_RE;
    cfg_wdata <= ore;
    @(posedge clk);
    cfg_addr  <= CFG_ORIGIN_IM;
    cfg_wdata <= oim;
    @(posedge clk);
    cfg_addr  <= CFG_STEP_RE;
    cfg_wdata <= sre;
    @(posedge clk);
    cfg_addr  <= CFG_STEP_IM;
    cfg_wdata <= sim;
    @(posedge clk);
    cfg_we    <= 1'b0;
    view_ore = ore;
    view_oim = oim;
    view_sre = sre;
    view_sim = sim;
  endtask

  // ---------------------------------------------------------------- result side

  task automatic check_result(input logic [OUT_TDATA_W-1:0] d);
    pixel_result_t want;
    if (pending.size() == 0) begin
      $error("result with no pending request: %h", d);
      mismatches++;
    end else begin
      want = pending.pop_front();
      if (d[8:0] !== want.iter_count) begin
        $error("iter_count: expected %0d, got %0d", want.iter_count, d[8:0]);
        mismatches++;
      end
      if (d[9] !== want.escaped) begin
        $error("escaped: expected %0d, got %0d", want.escaped, d[9]);
        mismatches++;
      end
      if (d[17:10] !== want.red) begin
        $error("red: expected %0d, got %0d", want.red, d[17:10]);
        mismatches++;
      end
      if (d[25:18] !== want.green) begin
        $error("green: expected %0d, got %0d", want.green, d[25:18]);
        mismatches++;
      end
      if (d[33:26] !== want.blue) begin
        $error("blue: expected %0d, got %0d", want.blue, d[33:26]);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      check_result(out_tdata);
    end
    if (hold_seen != hold_req) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(0, 99) >= 34);
    end
  end

  // ---------------------------------------------------------------- tests

  // reset view: corners, bit patterns, interior points
  task automatic test_reset_view();
    send_pixel(11'd0, 10'd0);
    send_pixel(11'd2047, 10'd1023);
    send_pixel(11'd2047, 10'd0);
    send_pixel(11'd0, 10'd1023);
    send_pixel(11'h555, 10'h155);
    send_pixel(11'h2aa, 10'h2aa);
    send_pixel(11'd1365, 10'd767);
    send_pixel(11'd975, 10'd384);   // near zero, stays bounded
    send_pixel(11'd585, 10'd384);   // period-two bulb
    send_pixel(11'd195, 10'd384);   // just left of -2
    send_pixel(11'd1072, 10'd384);  // near the cusp
    send_pixel(11'd1024, 10'd512);
    send_pixel(11'd1100, 10'd600);
    send_pixel(11'd900, 10'd700);
    send_pixel(11'd1, 10'd1);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    // map saturates high
    set_view(FX_MAX, FX_MAX, FX_MAX, FX_MAX);
    send_pixel(11'd0, 10'd0);
    send_pixel(11'd2047, 10'd1023);
    wait_drained();
    // map saturates low
    set_view(FX_MIN, FX_MIN, FX_MIN, FX_MIN);
    send_pixel(11'd1, 10'd1);
    send_pixel(11'd2047, 10'd1023);
    wait_drained();
    // mixed signs, overflowing products cancel against the origin
    set_view(FX_MAX, FX_MIN, FX_MIN, FX_MAX);
    send_pixel(11'd0, 10'd0);
    send_pixel(11'd2047, 10'd0);
    wait_drained();
    // c = 0 never escapes
    set_view('0, '0, '0, '0);
    send_pixel(11'd2047, 10'd1023);
    wait_drained();
    // c = -2 lands exactly on magnitude four
    set_view(64'sd0 - (64'sd2 <<< FRAC_BITS), '0, '0, '0);
    send_pixel(11'd5, 10'd7);
    wait_drained();
  endtask

  // wide random views, mostly outside the set so pixels finish quickly
  task automatic test_wide_views();
    for (int v = 0; v < 8; v++) begin
      if (v == 5) begin
        set_view({$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
      end else begin
        set_view(milli(int'($urandom_range(0, 11000)) - 6000),
                 milli(int'($urandom_range(0, 8000)) - 4000),
                 rand_step(int'($urandom_range(15, 16))),
                 rand_step(int'($urandom_range(14, 15))));
      end
      steady = (v == 3);
      repeat (125) send_random_pixel();
      steady = 1'b0;
      wait_drained();
    end
  endtask

  // narrow view in the neck near -0.75 where counts spread over all segments
  task automatic test_boundary_zoom();
    set_view(milli(-752), milli(5), milli(4) / 2048, milli(60) / 1024);
    repeat (48) send_random_pixel();
    wait_drained();
  endtask

  // output held off while fast pixels keep coming, so the input must stall
  task automatic test_output_stall();
    set_view(milli(3000), milli(-1000), 64'sd1 <<< 40, 64'sd1 <<< 40);
    steady = 1'b1;
    hold_req++;
    repeat (12) send_random_pixel();
    steady = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_view();
    test_register_extremes();
    test_wide_views();
    test_boundary_zoom();
    test_output_stall();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 20);
    $display("Mismatches found");
    $finish;
  end

endmodule
